### rtl/core/label_histogram_ranker_assert.svh
// Assertion macros for the label histogram ranker.
// Used by modules that check their own control logic; needs clock and reset in scope.
`ifndef LABEL_HISTOGRAM_RANKER_ASSERT_SVH
`define LABEL_HISTOGRAM_RANKER_ASSERT_SVH

// Check a property on every rising clock edge outside reset.
`define LHR_ASSERT(name, prop, msg) \
   name: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Check that a condition holds in the cycle after a trigger.
`define LHR_ASSERT_NEXT(name, trig, cond, msg) \
   `LHR_ASSERT(name, (trig) |=> (cond), msg)

`endif

### rtl/core/lhr_pkg.sv
// Shared types and constants of the label histogram ranker.
// No dependencies.
package lhr_pkg;

   localparam int NUM_LABELS_DEF = 64;
   localparam int PIXEL_BITS_DEF = 40;
   localparam int SCENE_BITS_DEF = 24;
   localparam int AVG_BITS       = 48;
   localparam int FRAC_BITS      = 8;
   localparam int QUEUE_DEPTH    = 4;

   localparam logic [2:0] OP_PIXEL     = 3'd0;
   localparam logic [2:0] OP_END_SCENE = 3'd1;
   localparam logic [2:0] OP_START     = 3'd2;
   localparam logic [2:0] OP_FINISH    = 3'd3;
   localparam logic [2:0] OP_QUERY     = 3'd4;
   localparam logic [2:0] OP_RANK      = 3'd5;

   localparam logic [1:0] KEY_AVG   = 2'd0;
   localparam logic [1:0] KEY_SCENE = 2'd1;
   localparam logic [1:0] KEY_PIXEL = 2'd2;

   typedef struct packed {
      logic [2:0] op;
      logic [5:0] label;
      logic [1:0] sort_key;
      logic       ascending;
      logic [6:0] top_count;
   } req_type;

   typedef struct packed {
      logic [5:0]  label_out;
      logic [39:0] pixel_total;
      logic [23:0] scene_total;
      logic [47:0] avg_pixels;
      logic        ready_res;
      logic        last;
   } rsp_type;

   typedef struct packed {
      logic [2:0] op;
      logic [5:0] label;
      logic       label_ok;
      logic [1:0] sort_key;
      logic       ascending;
      logic [6:0] top;
   } cmd_type;

   typedef struct packed {
      logic full;
      logic not_empty;
   } q_stat_type;

   typedef struct packed {
      logic busy;
      logic done;
   } div_stat_type;

endpackage

### rtl/core/label_histogram_ranker.sv
// Top level of the label histogram ranker: front end, command queue, back end.
// Depends on lhr_pkg, lhr_front, lhr_queue, lhr_back.
//
//   channel  | ports                    | handshake
//   ---------+--------------------------+-----------------------------------
//   request  | start, busy, req_data    | beat taken when start && !busy
//   response | rsp_valid, rsp_data      | beat taken on each rsp_valid cycle
//
// Request beats enter a 4-deep command queue, one per cycle while it has room.
// Back end rate is set by one read-modify-write port per count memory: a pixel
// op reads and then writes its count, an end scene op walks every label that way,
// a query runs the serial divider, and a rank first runs the average pass through
// the serial divider for every label, then scans all labels once per result.
// Reset and the start op clear the pixel and scene counts through their valid bits.
// Results are shown for one cycle each; the receiver cannot stall them.
module label_histogram_ranker #(
   parameter int NUM_LABELS       = lhr_pkg::NUM_LABELS_DEF,
   parameter int PIXEL_COUNT_BITS = lhr_pkg::PIXEL_BITS_DEF,
   parameter int SCENE_COUNT_BITS = lhr_pkg::SCENE_BITS_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  lhr_pkg::req_type req_data,
   output logic             rsp_valid,
   output lhr_pkg::rsp_type rsp_data
);
   import lhr_pkg::*;

   q_stat_type q_stat;
   cmd_type    push_cmd;
   cmd_type    head;
   logic       push;
   logic       pop;

   // classify the beat, drop unused op codes
   lhr_front #(
      .NUM_LABELS(NUM_LABELS)
   ) u_front (
      .req_data (req_data),
      .start    (start),
      .q_stat   (q_stat),
      .busy     (busy),
      .push     (push),
      .cmd      (push_cmd)
   );

   // hold commands while the back end works
   lhr_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_cmd),
      .pop       (pop),
      .q_stat    (q_stat),
      .head      (head)
   );

   // update counts, answer queries, run rankings
   lhr_back #(
      .NUM_LABELS      (NUM_LABELS),
      .PIXEL_COUNT_BITS(PIXEL_COUNT_BITS),
      .SCENE_COUNT_BITS(SCENE_COUNT_BITS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .head      (head),
      .q_stat    (q_stat),
      .pop       (pop),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

endmodule

### rtl/core/lhr_front.sv
// Front end: accepts request beats and classifies them into commands.
// Depends on lhr_pkg.
module lhr_front #(
   parameter int NUM_LABELS = lhr_pkg::NUM_LABELS_DEF
) (
   input  lhr_pkg::req_type    req_data,
   input  logic                start,
   input  lhr_pkg::q_stat_type q_stat,
   output logic                busy,
   output logic                push,
   output lhr_pkg::cmd_type    cmd
);
   import lhr_pkg::*;

   logic accept;

   assign busy   = q_stat.full;
   assign accept = start & ~q_stat.full;
   // drop unused op codes here, they never reach the back end
   assign push   = accept & (req_data.op <= OP_RANK);

   always_comb begin
      cmd.op        = req_data.op;
      cmd.label     = req_data.label;
      cmd.label_ok  = ({1'b0, req_data.label} < 7'(NUM_LABELS));
      cmd.sort_key  = req_data.sort_key;
      cmd.ascending = req_data.ascending;
      cmd.top       = (req_data.top_count > 7'(NUM_LABELS)) ? 7'(NUM_LABELS)
                                                            : req_data.top_count;
   end

endmodule

### rtl/core/lhr_queue.sv
// Short command queue between front and back end.
// Depends on lhr_pkg.
module lhr_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  lhr_pkg::cmd_type    push_data,
   input  logic                pop,
   output lhr_pkg::q_stat_type q_stat,
   output lhr_pkg::cmd_type    head
);
   import lhr_pkg::*;

   localparam int QP = $clog2(QUEUE_DEPTH);
   localparam int QC = $clog2(QUEUE_DEPTH + 1);

   cmd_type         qmem_ff [QUEUE_DEPTH];
   logic [QP-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QP-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QC-1:0]   cnt_ff, cnt_in;

   assign q_stat.full      = (cnt_ff == QC'(QUEUE_DEPTH));
   assign q_stat.not_empty = (cnt_ff != '0);
   assign head             = qmem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? QP'(wr_ptr_ff + 1'b1) : wr_ptr_ff;
      rd_ptr_in = pop  ? QP'(rd_ptr_ff + 1'b1) : rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (push && !pop) begin
         cnt_in = QC'(cnt_ff + 1'b1);
      end else if (pop && !push) begin
         cnt_in = QC'(cnt_ff - 1'b1);
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         qmem_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

endmodule

### rtl/core/lhr_div.sv
// Bit-serial restoring divider for the fixed-point average.
// Depends on lhr_pkg.
module lhr_div #(
   parameter int PIXEL_COUNT_BITS = lhr_pkg::PIXEL_BITS_DEF,
   parameter int SCENE_COUNT_BITS = lhr_pkg::SCENE_BITS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [PIXEL_COUNT_BITS-1:0]   pixels,
   input  logic [SCENE_COUNT_BITS-1:0]   scenes,
   output lhr_pkg::div_stat_type         stat,
   output logic [lhr_pkg::AVG_BITS-1:0]  quot
);
   import lhr_pkg::*;

   localparam int PB = PIXEL_COUNT_BITS;
   localparam int SB = SCENE_COUNT_BITS;
   localparam int DW = PB + FRAC_BITS;
   localparam int CW = $clog2(DW + 1);

   logic [DW-1:0] dvd_ff, dvd_in;
   logic [DW-1:0] quo_ff, quo_in;
   logic [SB-1:0] rem_ff, rem_in;
   logic [SB-1:0] dsr_ff, dsr_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic          run_ff, run_in;
   logic          done_ff, done_in;
   logic          zero_ff, zero_in;
   logic [SB:0]   trial;
   logic [AVG_BITS-1:0] sat_quo;

   assign trial = {rem_ff, dvd_ff[DW-1]};

   always_comb begin
      dvd_in  = dvd_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;
      cnt_in  = cnt_ff;
      run_in  = run_ff;
      zero_in = zero_ff;
      done_in = 1'b0;
      if (start) begin
         dvd_in  = {pixels, {FRAC_BITS{1'b0}}};
         quo_in  = '0;
         rem_in  = '0;
         dsr_in  = scenes;
         cnt_in  = CW'(DW);
         run_in  = 1'b1;
         zero_in = (scenes == '0);
      end else if (run_ff) begin
         // one quotient bit per cycle
         if (trial >= {1'b0, dsr_ff}) begin
            rem_in = SB'(trial - {1'b0, dsr_ff});
            quo_in = {quo_ff[DW-2:0], 1'b1};
         end else begin
            rem_in = trial[SB-1:0];
            quo_in = {quo_ff[DW-2:0], 1'b0};
         end
         dvd_in = {dvd_ff[DW-2:0], 1'b0};
         cnt_in = CW'(cnt_ff - 1'b1);
         if (cnt_ff == CW'(1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   generate
      if (DW > AVG_BITS) begin : g_sat
         assign sat_quo = (|quo_ff[DW-1:AVG_BITS]) ? {AVG_BITS{1'b1}}
                                                   : quo_ff[AVG_BITS-1:0];
      end else begin : g_nosat
         assign sat_quo = AVG_BITS'(quo_ff);
      end
   endgenerate

   assign quot      = zero_ff ? '0 : sat_quo;
   assign stat.busy = run_ff;
   assign stat.done = done_ff;

   always_ff @(posedge clock) begin
      dvd_ff  <= dvd_in;
      quo_ff  <= quo_in;
      rem_ff  <= rem_in;
      dsr_ff  <= dsr_in;
      cnt_ff  <= cnt_in;
      zero_ff <= zero_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
      end
   end

endmodule

### rtl/core/lhr_back.sv
// Back end: executes commands against the count memories and ranks labels.
// Depends on lhr_pkg, lhr_div and label_histogram_ranker_assert.svh.
module lhr_back #(
   parameter int NUM_LABELS       = lhr_pkg::NUM_LABELS_DEF,
   parameter int PIXEL_COUNT_BITS = lhr_pkg::PIXEL_BITS_DEF,
   parameter int SCENE_COUNT_BITS = lhr_pkg::SCENE_BITS_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  lhr_pkg::cmd_type    head,
   input  lhr_pkg::q_stat_type q_stat,
   output logic                pop,
   output logic                rsp_valid,
   output lhr_pkg::rsp_type    rsp_data
);
   import lhr_pkg::*;
   `include "label_histogram_ranker_assert.svh"

   localparam int PB = PIXEL_COUNT_BITS;
   localparam int SB = SCENE_COUNT_BITS;
   localparam int IW = $clog2(NUM_LABELS);
   localparam int KW = AVG_BITS;
   localparam logic [IW-1:0] LAST_IDX = IW'(NUM_LABELS - 1);

   localparam logic [3:0] ST_IDLE     = 4'd0;
   localparam logic [3:0] ST_PIX_WR   = 4'd1;
   localparam logic [3:0] ST_END_RD   = 4'd2;
   localparam logic [3:0] ST_END_WR   = 4'd3;
   localparam logic [3:0] ST_Q_DIV    = 4'd4;
   localparam logic [3:0] ST_Q_WAIT   = 4'd5;
   localparam logic [3:0] ST_AVG_RD   = 4'd6;
   localparam logic [3:0] ST_AVG_DIV  = 4'd7;
   localparam logic [3:0] ST_AVG_WAIT = 4'd8;
   localparam logic [3:0] ST_SCAN     = 4'd9;
   localparam logic [3:0] ST_SCAN_END = 4'd10;
   localparam logic [3:0] ST_EMIT_RD  = 4'd11;
   localparam logic [3:0] ST_EMIT     = 4'd12;

   // count memories
   logic [PB-1:0]       pix_mem_ff [NUM_LABELS];
   logic [SB-1:0]       scn_mem_ff [NUM_LABELS];
   logic [KW-1:0]       avg_mem_ff [NUM_LABELS];
   logic [PB-1:0]       pix_rd_ff;
   logic [SB-1:0]       scn_rd_ff;
   logic [KW-1:0]       avg_rd_ff;
   logic                pix_rd_vld_ff;
   logic                scn_rd_vld_ff;

   logic [3:0]            state_ff, state_in;
   cmd_type               cmd_ff, cmd_in;
   logic [IW-1:0]         idx_ff, idx_in;
   logic [6:0]            k_ff, k_in;
   logic [NUM_LABELS-1:0] used_ff, used_in;
   logic [NUM_LABELS-1:0] seen_ff, seen_in;
   logic [NUM_LABELS-1:0] pix_vld_ff, pix_vld_in;
   logic [NUM_LABELS-1:0] scn_vld_ff, scn_vld_in;
   logic                  ready_ff, ready_in;
   logic                  found_ff, found_in;
   logic [IW-1:0]         best_ff, best_in;
   logic [KW-1:0]         bv_ff, bv_in;
   logic                  cmp_vld_ff, cmp_vld_in;
   logic [IW-1:0]         cmp_idx_ff, cmp_idx_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   rsp_type               rsp_ff, rsp_in;

   logic [IW-1:0]  rd_addr, wr_addr, cmd_lab;
   logic           pix_we, scn_we, avg_we;
   logic [PB-1:0]  pix_val;
   logic [SB-1:0]  scn_val;
   logic [63:0]    pix_ext, scn_ext;
   logic [KW-1:0]  kv;
   logic           better;
   logic           rank_last;
   logic           div_start;
   div_stat_type   div_stat;
   logic [KW-1:0]  div_quot;

   lhr_div #(
      .PIXEL_COUNT_BITS(PB),
      .SCENE_COUNT_BITS(SB)
   ) u_div (
      .clock  (clock),
      .reset  (reset),
      .start  (div_start),
      .pixels (pix_val),
      .scenes (scn_val),
      .stat   (div_stat),
      .quot   (div_quot)
   );

   assign cmd_lab   = cmd_ff.label[IW-1:0];
   assign pix_val   = pix_rd_vld_ff ? pix_rd_ff : '0;
   assign scn_val   = scn_rd_vld_ff ? scn_rd_ff : '0;
   assign pix_ext   = 64'(pix_val);
   assign scn_ext   = 64'(scn_val);
   assign rank_last = (7'(k_ff + 7'd1) == cmd_ff.top);

   always_comb begin
      case (cmd_ff.sort_key)
         KEY_AVG:   kv = avg_rd_ff;
         KEY_SCENE: kv = KW'(scn_val);
         KEY_PIXEL: kv = KW'(pix_val);
         default:   kv = '0;
      endcase
      better = !found_ff || (cmd_ff.ascending ? (kv < bv_ff) : (kv > bv_ff));
   end

   always_comb begin
      case (state_ff)
         ST_IDLE:                            rd_addr = head.label[IW-1:0];
         ST_PIX_WR, ST_Q_DIV, ST_Q_WAIT:     rd_addr = cmd_lab;
         ST_EMIT_RD, ST_EMIT:                rd_addr = best_ff;
         default:                            rd_addr = idx_ff;
      endcase
      wr_addr = (state_ff == ST_PIX_WR) ? cmd_lab : idx_ff;
   end

   always_comb begin
      state_in     = state_ff;
      cmd_in       = cmd_ff;
      idx_in       = idx_ff;
      k_in         = k_ff;
      used_in      = used_ff;
      seen_in      = seen_ff;
      pix_vld_in   = pix_vld_ff;
      scn_vld_in   = scn_vld_ff;
      ready_in     = ready_ff;
      found_in     = found_ff;
      best_in      = best_ff;
      bv_in        = bv_ff;
      cmp_vld_in   = 1'b0;
      cmp_idx_in   = cmp_idx_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_ff;
      pop          = 1'b0;
      pix_we       = 1'b0;
      scn_we       = 1'b0;
      avg_we       = 1'b0;
      div_start    = 1'b0;

      // compare stage of the ranking scan, one label a cycle
      if (cmp_vld_ff && !used_ff[cmp_idx_ff] && better) begin
         best_in  = cmp_idx_ff;
         bv_in    = kv;
         found_in = 1'b1;
      end

      case (state_ff)
         ST_IDLE: begin
            if (q_stat.not_empty) begin
               pop    = 1'b1;
               cmd_in = head;
               case (head.op)
                  OP_PIXEL: begin
                     if (head.label_ok) begin
                        state_in = ST_PIX_WR;
                     end
                  end
                  OP_END_SCENE: begin
                     idx_in   = '0;
                     state_in = ST_END_RD;
                  end
                  OP_START: begin
                     pix_vld_in = '0;
                     scn_vld_in = '0;
                     seen_in    = '0;
                     ready_in   = 1'b0;
                  end
                  OP_FINISH: begin
                     ready_in = 1'b1;
                  end
                  OP_QUERY: begin
                     if (ready_ff && head.label_ok) begin
                        state_in = ST_Q_DIV;
                     end else begin
                        rsp_valid_in     = 1'b1;
                        rsp_in           = '0;
                        rsp_in.label_out = head.label;
                        rsp_in.ready_res = ready_ff;
                        rsp_in.last      = 1'b1;
                     end
                  end
                  OP_RANK: begin
                     if (!ready_ff) begin
                        rsp_valid_in = 1'b1;
                        rsp_in       = '0;
                        rsp_in.last  = 1'b1;
                     end else if (head.sort_key <= KEY_PIXEL && head.top != '0) begin
                        idx_in   = '0;
                        k_in     = '0;
                        used_in  = '0;
                        state_in = ST_AVG_RD;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_PIX_WR: begin
            pix_we              = 1'b1;
            pix_vld_in[cmd_lab] = 1'b1;
            seen_in[cmd_lab]    = 1'b1;
            state_in            = ST_IDLE;
         end
         ST_END_RD: begin
            state_in = ST_END_WR;
         end
         ST_END_WR: begin
            if (seen_ff[idx_ff]) begin
               scn_we             = 1'b1;
               scn_vld_in[idx_ff] = 1'b1;
            end
            seen_in[idx_ff] = 1'b0;
            if (idx_ff == LAST_IDX) begin
               state_in = ST_IDLE;
            end else begin
               idx_in   = IW'(idx_ff + 1'b1);
               state_in = ST_END_RD;
            end
         end
         ST_Q_DIV: begin
            div_start = 1'b1;
            state_in  = ST_Q_WAIT;
         end
         ST_Q_WAIT: begin
            if (div_stat.done) begin
               rsp_valid_in       = 1'b1;
               rsp_in.label_out   = cmd_ff.label;
               rsp_in.pixel_total = pix_ext[39:0];
               rsp_in.scene_total = scn_ext[23:0];
               rsp_in.avg_pixels  = div_quot;
               rsp_in.ready_res   = 1'b1;
               rsp_in.last        = 1'b1;
               state_in           = ST_IDLE;
            end
         end
         ST_AVG_RD: begin
            state_in = ST_AVG_DIV;
         end
         ST_AVG_DIV: begin
            div_start = 1'b1;
            state_in  = ST_AVG_WAIT;
         end
         ST_AVG_WAIT: begin
            if (div_stat.done) begin
               avg_we = 1'b1;
               if (idx_ff == LAST_IDX) begin
                  idx_in   = '0;
                  found_in = 1'b0;
                  state_in = ST_SCAN;
               end else begin
                  idx_in   = IW'(idx_ff + 1'b1);
                  state_in = ST_AVG_RD;
               end
            end
         end
         ST_SCAN: begin
            cmp_vld_in = 1'b1;
            cmp_idx_in = idx_ff;
            if (idx_ff == LAST_IDX) begin
               state_in = ST_SCAN_END;
            end else begin
               idx_in = IW'(idx_ff + 1'b1);
            end
         end
         ST_SCAN_END: begin
            state_in = ST_EMIT_RD;
         end
         ST_EMIT_RD: begin
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            rsp_valid_in       = 1'b1;
            rsp_in.label_out   = 6'(best_ff);
            rsp_in.pixel_total = pix_ext[39:0];
            rsp_in.scene_total = scn_ext[23:0];
            rsp_in.avg_pixels  = avg_rd_ff;
            rsp_in.ready_res   = 1'b1;
            rsp_in.last        = rank_last;
            used_in[best_ff]   = 1'b1;
            k_in               = 7'(k_ff + 7'd1);
            if (rank_last) begin
               state_in = ST_IDLE;
            end else begin
               idx_in   = '0;
               found_in = 1'b0;
               state_in = ST_SCAN;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (pix_we) begin
         pix_mem_ff[wr_addr] <= (&pix_val) ? pix_val : PB'(pix_val + 1'b1);
      end
      if (scn_we) begin
         scn_mem_ff[wr_addr] <= (&scn_val) ? scn_val : SB'(scn_val + 1'b1);
      end
      if (avg_we) begin
         avg_mem_ff[wr_addr] <= div_quot;
      end
      pix_rd_ff     <= pix_mem_ff[rd_addr];
      scn_rd_ff     <= scn_mem_ff[rd_addr];
      avg_rd_ff     <= avg_mem_ff[rd_addr];
      pix_rd_vld_ff <= pix_vld_ff[rd_addr];
      scn_rd_vld_ff <= scn_vld_ff[rd_addr];
   end

   always_ff @(posedge clock) begin
      cmd_ff     <= cmd_in;
      best_ff    <= best_in;
      bv_ff      <= bv_in;
      cmp_idx_ff <= cmp_idx_in;
      rsp_ff     <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         idx_ff       <= '0;
         k_ff         <= '0;
         used_ff      <= '0;
         seen_ff      <= '0;
         pix_vld_ff   <= '0;
         scn_vld_ff   <= '0;
         ready_ff     <= 1'b0;
         found_ff     <= 1'b0;
         cmp_vld_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         idx_ff       <= idx_in;
         k_ff         <= k_in;
         used_ff      <= used_in;
         seen_ff      <= seen_in;
         pix_vld_ff   <= pix_vld_in;
         scn_vld_ff   <= scn_vld_in;
         ready_ff     <= ready_in;
         found_ff     <= found_in;
         cmp_vld_ff   <= cmp_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   `LHR_ASSERT(a_div_start_idle, div_start |-> !div_stat.busy, "divider restarted while busy")
   `LHR_ASSERT_NEXT(a_div_runs, div_start, div_stat.busy, "divider did not start")
   `LHR_ASSERT(a_emit_unused, (state_ff == ST_EMIT) |-> !used_ff[best_ff], "label ranked twice")
   `LHR_ASSERT(a_scan_bound, (state_ff == ST_SCAN) |-> (k_ff < cmd_ff.top), "rank ran past top")

endmodule

### tb/sv/label_histogram_ranker_checker.sv
`timescale 1ns / 100ps
// Checker for the label histogram ranker: watches request and response beats,
// predicts the label statistics and compares every response. Depends on lhr_pkg.
module label_histogram_ranker_checker (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic             busy,
   input  lhr_pkg::req_type req_data,
   input  logic             rsp_valid,
   input  lhr_pkg::rsp_type rsp_data,
   output int               fail_count,
   output int               pending,
   output int               beats_checked
);
   import lhr_pkg::*;

   localparam int LABELS = 64;

   logic [39:0] pixel_tally [LABELS];
   logic [23:0] scene_tally [LABELS];
   logic        seen_mark   [LABELS];
   logic        stats_done;
   rsp_type     expected_beats [$];

   function automatic logic [47:0] mean_pixels(int idx);
      logic [63:0] wide;
      if (scene_tally[idx] == '0) return '0;
      wide = {24'd0, pixel_tally[idx]} << 8;
      wide = wide / {40'd0, scene_tally[idx]};
      return (wide > 64'hFFFF_FFFF_FFFF) ? 48'hFFFF_FFFF_FFFF : wide[47:0];
   endfunction

   function automatic logic [47:0] rank_key(int idx, logic [1:0] key);
      if (key == KEY_AVG) return mean_pixels(idx);
      if (key == KEY_SCENE) return {24'd0, scene_tally[idx]};
      return {8'd0, pixel_tally[idx]};
   endfunction

   function automatic rsp_type stats_beat(int idx, logic fin);
      rsp_type b;
      b.label_out   = idx[5:0];
      b.pixel_total = pixel_tally[idx];
      b.scene_total = scene_tally[idx];
      b.avg_pixels  = mean_pixels(idx);
      b.ready_res   = 1'b1;
      b.last        = fin;
      return b;
   endfunction

   task automatic clear_stats();
      for (int i = 0; i < LABELS; i++) begin
         pixel_tally[i] = '0;
         scene_tally[i] = '0;
         seen_mark[i]   = 1'b0;
      end
      stats_done = 1'b0;
   endtask

   task automatic predict_beat(req_type r);
      rsp_type     b;
      logic        used [LABELS];
      int          n, best;
      logic [47:0] bv, v;
      logic        found;
      case (r.op)
         OP_PIXEL: begin
            if (pixel_tally[r.label] != '1) pixel_tally[r.label]++;
            seen_mark[r.label] = 1'b1;
         end
         OP_END_SCENE: begin
            for (int i = 0; i < LABELS; i++) begin
               if (seen_mark[i] && scene_tally[i] != '1) scene_tally[i]++;
               seen_mark[i] = 1'b0;
            end
         end
         OP_START:  clear_stats();
         OP_FINISH: stats_done = 1'b1;
         OP_QUERY: begin
            if (stats_done) begin
               expected_beats.push_back(stats_beat(int'(r.label), 1'b1));
            end else begin
               b = '0;
               b.label_out = r.label;
               b.last = 1'b1;
               expected_beats.push_back(b);
            end
         end
         OP_RANK: begin
            if (!stats_done) begin
               b = '0;
               b.last = 1'b1;
               expected_beats.push_back(b);
            end else if (r.sort_key <= KEY_PIXEL && r.top_count != 0) begin
               n = (r.top_count > LABELS) ? LABELS : int'(r.top_count);
               for (int i = 0; i < LABELS; i++) used[i] = 1'b0;
               for (int k = 0; k < n; k++) begin
                  found = 1'b0;
                  best = 0;
                  bv = '0;
                  // strict compare keeps the lower label on a tie
                  for (int i = 0; i < LABELS; i++) begin
                     if (!used[i]) begin
                        v = rank_key(i, r.sort_key);
                        if (!found || (r.ascending ? (v < bv) : (v > bv))) begin
                           best = i;
                           bv = v;
                           found = 1'b1;
                        end
                     end
                  end
                  used[best] = 1'b1;
                  expected_beats.push_back(stats_beat(best, k + 1 == n));
               end
            end
         end
         default: ;
      endcase
   endtask

   task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
      $display("[%0t] mismatch %s: got %0h expected %0h", $time, what, got, want);
      fail_count++;
   endtask

   always @(posedge clock) begin
      rsp_type e;
      if (reset) begin
         clear_stats();
         expected_beats.delete();
         fail_count = 0;
         beats_checked = 0;
      end else begin
         if (rsp_valid) begin
            if (expected_beats.size() == 0) begin
               report_mismatch("unexpected response beat", 64'(rsp_data.label_out), 64'd0);
            end else begin
               e = expected_beats.pop_front();
               beats_checked++;
               if (rsp_data.label_out != e.label_out)
                  report_mismatch("label_out", 64'(rsp_data.label_out), 64'(e.label_out));
               if (rsp_data.pixel_total != e.pixel_total)
                  report_mismatch("pixel_total", 64'(rsp_data.pixel_total),
                                  64'(e.pixel_total));
               if (rsp_data.scene_total != e.scene_total)
                  report_mismatch("scene_total", 64'(rsp_data.scene_total),
                                  64'(e.scene_total));
               if (rsp_data.avg_pixels != e.avg_pixels)
                  report_mismatch("avg_pixels", 64'(rsp_data.avg_pixels), 64'(e.avg_pixels));
               if (rsp_data.ready_res != e.ready_res)
                  report_mismatch("ready_res", 64'(rsp_data.ready_res), 64'(e.ready_res));
               if (rsp_data.last != e.last)
                  report_mismatch("last", 64'(rsp_data.last), 64'(e.last));
            end
         end
         if (start && !busy) predict_beat(req_data);
      end
      pending <= expected_beats.size();
   end
endmodule

### tb/sv/label_histogram_ranker_tb.sv
`timescale 1ns / 100ps
// Top of the label histogram ranker testbench: clock, reset, request stimulus
// and verdict. Depends on lhr_pkg, label_histogram_ranker and its checker.
module label_histogram_ranker_tb;
   import lhr_pkg::*;

   localparam int CYCLE_LIMIT = 10_000_000;
   // longest back-end run: average pass plus a full 64-result ranking
   localparam int DRAIN_CYCLES = 8000;

   // op and key codes the block ignores
   localparam logic [2:0] OP_SPARE_LO = 3'd6;
   localparam logic [2:0] OP_SPARE_HI = 3'd7;
   localparam logic [1:0] KEY_NONE    = 2'd3;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    start = 1'b0;
   logic    busy;
   req_type req_data = '0;
   logic    rsp_valid;
   rsp_type rsp_data;
   int      fail_count, pending, beats_checked;
   int      items_sent = 0;
   int      cycles = 0;

   always #10 clock = ~clock;

   label_histogram_ranker dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_data(req_data), .rsp_valid(rsp_valid), .rsp_data(rsp_data)
   );

   label_histogram_ranker_checker chk (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_data(req_data), .rsp_valid(rsp_valid), .rsp_data(rsp_data),
      .fail_count(fail_count), .pending(pending), .beats_checked(beats_checked)
   );

   // Stop a hung run.
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycles);
         $display("label_histogram_ranker test failed");
         $finish;
      end
   end

   // Drive one request beat at the falling edge and hold it until taken.
   // Start stays high between back-to-back beats; a gap drops it first.
   task automatic send_beat(logic [2:0] op, logic [5:0] label, logic [1:0] key,
                            logic asc, logic [6:0] top);
      int roll, gap;
      roll = $urandom_range(0, 99);
      if (roll < 55) gap = 0;
      else if (roll < 90) gap = $urandom_range(1, 3);
      else gap = $urandom_range(5, 40);
      repeat (gap) begin
         @(negedge clock);
         start = 1'b0;
      end
      @(negedge clock);
      start = 1'b1;
      req_data = '{op: op, label: label, sort_key: key, ascending: asc, top_count: top};
      do @(posedge clock); while (busy);
      items_sent++;
   endtask

   // Random top count: mostly short rankings, a few full, oversized or zero ones.
   function automatic logic [6:0] pick_top();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 75) return 7'($urandom_range(1, 8));
      if (roll < 85) return 7'd64;
      if (roll < 93) return 7'($urandom_range(65, 127));
      return 7'd0;
   endfunction

   initial begin
      int nscenes, npix, span;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed part: not-ready replies, extreme labels, every op and rank case.
      send_beat(OP_QUERY, 6'd63, KEY_AVG, 1'b0, 7'd0);
      send_beat(OP_RANK, 6'd0, KEY_PIXEL, 1'b1, 7'd64);
      send_beat(OP_PIXEL, 6'd0, KEY_AVG, 1'b0, 7'd0);
      send_beat(OP_PIXEL, 6'd63, KEY_AVG, 1'b0, 7'd0);
      send_beat(OP_PIXEL, 6'd63, KEY_AVG, 1'b0, 7'd0);
      send_beat(OP_END_SCENE, 6'd0, KEY_AVG, 1'b0, 7'd0);
      send_beat(OP_PIXEL, 6'd63, KEY_AVG, 1'b0, 7'd0);
      send_beat(OP_PIXEL, 6'd42, KEY_AVG, 1'b0, 7'd0);
      send_beat(OP_FINISH, 6'd0, KEY_AVG, 1'b0, 7'd0);     // scene left open
      send_beat(OP_QUERY, 6'd63, KEY_AVG, 1'b0, 7'd0);
      send_beat(OP_QUERY, 6'd42, KEY_AVG, 1'b0, 7'd0);     // pixels but no scene
      send_beat(OP_END_SCENE, 6'd0, KEY_AVG, 1'b0, 7'd0);  // counts after finish
      send_beat(OP_QUERY, 6'd0, KEY_AVG, 1'b0, 7'd0);
      send_beat(OP_RANK, 6'd0, KEY_AVG, 1'b0, 7'd4);
      send_beat(OP_RANK, 6'd0, KEY_SCENE, 1'b1, 7'd3);
      send_beat(OP_RANK, 6'd0, KEY_PIXEL, 1'b0, 7'd64);
      send_beat(OP_RANK, 6'd0, KEY_PIXEL, 1'b1, 7'd127);
      send_beat(OP_RANK, 6'd0, KEY_NONE, 1'b0, 7'd5);       // bad key, no beats
      send_beat(OP_RANK, 6'd0, KEY_AVG, 1'b1, 7'd0);        // zero count, no beats
      send_beat(OP_SPARE_LO, 6'd21, KEY_AVG, 1'b0, 7'd1);
      send_beat(OP_SPARE_HI, 6'd42, KEY_SCENE, 1'b1, 7'd2);
      send_beat(OP_START, 6'd0, KEY_AVG, 1'b0, 7'd0);
      send_beat(OP_QUERY, 6'd63, KEY_AVG, 1'b0, 7'd0);      // cleared, not ready

      // Random part: well-formed runs of scenes with random content,
      // then finish and a few reports; some noise mixed in.
      while (items_sent < 245) begin
         if ($urandom_range(0, 9) != 0) send_beat(OP_START, 6'd0, KEY_AVG, 1'b0, 7'd0);
         nscenes = $urandom_range(1, 5);
         span = ($urandom_range(0, 1) != 0) ? 7 : 63;   // narrow span forces ties
         for (int s = 0; s < nscenes; s++) begin
            npix = $urandom_range(1, 14);
            for (int p = 0; p < npix; p++)
               send_beat(OP_PIXEL, 6'($urandom_range(0, span)), 2'($urandom_range(0, 3)),
                         1'($urandom_range(0, 1)), 7'($urandom_range(0, 127)));
            if ($urandom_range(0, 7) == 0)
               send_beat(OP_QUERY, 6'($urandom_range(0, 63)), KEY_AVG, 1'b0, 7'd0);
            if ($urandom_range(0, 5) != 0)
               send_beat(OP_END_SCENE, 6'd0, KEY_AVG, 1'b0, 7'd0);
         end
         if ($urandom_range(0, 5) != 0) send_beat(OP_FINISH, 6'd0, KEY_AVG, 1'b0, 7'd0);
         for (int q = $urandom_range(1, 3); q > 0; q--)
            send_beat(OP_QUERY, 6'($urandom_range(0, 63)), 2'($urandom_range(0, 3)),
                      1'($urandom_range(0, 1)), 7'd0);
         send_beat(OP_RANK, 6'd0,
                   ($urandom_range(0, 9) == 0) ? KEY_NONE : 2'($urandom_range(0, 2)),
                   1'($urandom_range(0, 1)), pick_top());
         if ($urandom_range(0, 7) == 0)
            send_beat(3'($urandom_range(int'(OP_SPARE_LO), int'(OP_SPARE_HI))),
                      6'($urandom_range(0, 63)), 2'($urandom_range(0, 3)),
                      1'($urandom_range(0, 1)), 7'($urandom_range(0, 127)));
      end
      @(negedge clock);
      start = 1'b0;

      // Drain outstanding results, then let the back end settle.
      while (pending != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("sent %0d request beats over %0d cycles", items_sent, cycles);
      $display("checked %0d response beats, %0d mismatches", beats_checked, fail_count);
      if (fail_count == 0 && pending == 0) begin
         $display("label_histogram_ranker test passed");
      end else begin
         $display("label_histogram_ranker test failed");
      end
      $finish;
   end
endmodule
